FILE: src/kcpl_pkg.sv
// kcpl_pkg: sizes, codes and the binary search step for the class pair kerning lookup
// no dependencies; used by kern_class_pair_lookup_unit
`default_nettype none

package kcpl_pkg;

  // store depths
  localparam int LEFT_ENTRIES  = 256;
  localparam int RIGHT_ENTRIES = 256;
  localparam int MATRIX_DEPTH  = 4096;

  // address widths of the three memories
  localparam int LEFT_AW  = (LEFT_ENTRIES > 1) ? $clog2(LEFT_ENTRIES) : 1;
  localparam int RIGHT_AW = (RIGHT_ENTRIES > 1) ? $clog2(RIGHT_ENTRIES) : 1;
  localparam int MAT_AW   = (MATRIX_DEPTH > 1) ? $clog2(MATRIX_DEPTH) : 1;

  // search counters hold 0 .. table depth
  localparam int MAX_ENTRIES = (LEFT_ENTRIES > RIGHT_ENTRIES) ? LEFT_ENTRIES : RIGHT_ENTRIES;
  localparam int SRCH_W      = $clog2(MAX_ENTRIES + 1);

  // field widths
  localparam int KIND_W  = 2;
  localparam int SLOT_W  = 12;
  localparam int CP_W    = 21;
  localparam int KEY_W   = 16;
  localparam int CLASS_W = 8;
  localparam int WORD_W  = 8;
  localparam int ENTRY_W = KEY_W + CLASS_W;
  localparam int WIDE_W  = 16;
  localparam int IDX_W   = 2 * CLASS_W;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int COUNT_W    = 9;

  localparam logic [CFG_IDX_W-1:0] REG_KERN_ENABLE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_ENTRY_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_ENTRY_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_CLASS_COUNT = 2'd3;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_LOAD_LEFT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_RIGHT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOAD_WORD  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY      = 2'd3;

  // window of a lower-bound search
  typedef struct packed {
    logic [SRCH_W-1:0] lo;
    logic [SRCH_W-1:0] n;
  } srch_t;

  // one probe: narrow the window around the key read at lo + n/2
  function automatic srch_t kcpl_probe(srch_t cur, logic [KEY_W-1:0] key,
                                       logic [KEY_W-1:0] cp);
    logic [SRCH_W-1:0] half;
    logic [SRCH_W-1:0] mid;
    srch_t             nxt;
    half = cur.n >> 1;
    mid  = cur.lo + half;
    if (key < cp) begin
      nxt.lo = mid + SRCH_W'(1);
      nxt.n  = cur.n - half - SRCH_W'(1);
    end else begin
      nxt.lo = cur.lo;
      nxt.n  = half;
    end
    return nxt;
  endfunction

  // entry to read next: the next probe, or the final match check at lo
  function automatic logic [SRCH_W-1:0] kcpl_addr(srch_t win);
    logic [SRCH_W-1:0] addr;
    if (win.n != '0) begin
      addr = win.lo + (win.n >> 1);
    end else begin
      addr = win.lo;
    end
    return addr;
  endfunction

endpackage

`default_nettype wire

FILE: src/kern_class_pair_lookup_unit.sv
// kern_class_pair_lookup_unit: class based kerning pair lookup over two class tables
// and a signed kern matrix, all held in synchronous memories; uses kcpl_pkg
`default_nettype none

// channel    direction  handshake               payload
// request    in         req_valid / req_stall   kind, slot, left_codepoint, right_codepoint,
//                                               class_number, kern_word
// result     out        res_valid / res_stall   kern_adjust, out_of_range
// config     in         cfg_write               cfg_index, cfg_data
//
// a load does not keep the block busy: the memory write happens at the accepting edge
// a query probes both tables at once from its accepting edge; then the match check, end of
// search, multiply, index check, matrix read and output follow in that order; skipped searches
// and pairs that never reach the matrix finish sooner
// rst clears control and configuration state; memories stay undefined; a stalled result does not
// block the next request, but a finished query waits in delivery until the output is free

module kern_class_pair_lookup_unit (
  input  wire                                clk,
  input  wire                                rst,
  // request channel
  input  wire                                req_valid,
  output logic                               req_stall,
  input  wire  [kcpl_pkg::KIND_W-1:0]        kind,
  input  wire  [kcpl_pkg::SLOT_W-1:0]        slot,
  input  wire  [kcpl_pkg::CP_W-1:0]          left_codepoint,
  input  wire  [kcpl_pkg::CP_W-1:0]          right_codepoint,
  input  wire  [kcpl_pkg::CLASS_W-1:0]       class_number,
  input  wire  signed [kcpl_pkg::WORD_W-1:0] kern_word,
  // result channel
  output logic                               res_valid,
  input  wire                                res_stall,
  output logic signed [kcpl_pkg::WORD_W-1:0] kern_adjust,
  output logic                               out_of_range,
  // configuration
  input  wire                                cfg_write,
  input  wire  [kcpl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [kcpl_pkg::CFG_DATA_W-1:0]    cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_MULT,
    ST_INDEX,
    ST_FETCH,
    ST_DELIVER
  } state_t;

  // per table search progress
  typedef enum logic [1:0] {
    PH_PROBE,
    PH_CHECK,
    PH_DONE
  } phase_t;

  state_t state;

  // configuration registers
  logic                            kern_enable;
  logic [kcpl_pkg::COUNT_W-1:0]    left_entry_count;
  logic [kcpl_pkg::COUNT_W-1:0]    right_entry_count;
  logic [kcpl_pkg::CLASS_W-1:0]    right_class_count;

  // memories
  logic [kcpl_pkg::ENTRY_W-1:0]    left_mem  [kcpl_pkg::LEFT_ENTRIES];
  logic [kcpl_pkg::ENTRY_W-1:0]    right_mem [kcpl_pkg::RIGHT_ENTRIES];
  logic signed [kcpl_pkg::WORD_W-1:0] mat_mem [kcpl_pkg::MATRIX_DEPTH];

  logic [kcpl_pkg::ENTRY_W-1:0]    l_rdata;
  logic [kcpl_pkg::ENTRY_W-1:0]    r_rdata;
  logic signed [kcpl_pkg::WORD_W-1:0] m_rdata;

  // request decode
  logic                            req_take;
  logic                            take_query;
  logic                            ld_left;
  logic                            ld_right;
  logic                            ld_word;
  logic [kcpl_pkg::WIDE_W-1:0]     slot_wide;
  logic [kcpl_pkg::ENTRY_W-1:0]    ld_entry;

  // search state, one set per table
  phase_t                          l_ph;
  phase_t                          r_ph;
  kcpl_pkg::srch_t                 l_win;
  kcpl_pkg::srch_t                 r_win;
  logic [kcpl_pkg::KEY_W-1:0]      l_cp;
  logic [kcpl_pkg::KEY_W-1:0]      r_cp;
  logic [kcpl_pkg::CLASS_W-1:0]    l_cls;
  logic [kcpl_pkg::CLASS_W-1:0]    r_cls;

  kcpl_pkg::srch_t                 l_step;
  kcpl_pkg::srch_t                 r_step;
  logic [kcpl_pkg::SRCH_W-1:0]     l_cnt_eff;
  logic [kcpl_pkg::SRCH_W-1:0]     r_cnt_eff;
  logic                            l_skip;
  logic                            r_skip;
  logic [kcpl_pkg::SRCH_W-1:0]     l_raddr_w;
  logic [kcpl_pkg::SRCH_W-1:0]     r_raddr_w;
  logic [kcpl_pkg::LEFT_AW-1:0]    l_raddr;
  logic [kcpl_pkg::RIGHT_AW-1:0]   r_raddr;

  // matrix index path
  logic [kcpl_pkg::CLASS_W-1:0]    lc_m1;
  logic [kcpl_pkg::IDX_W-1:0]      prod;
  logic [kcpl_pkg::CLASS_W-1:0]    rc_m1;
  logic                            pair_ok;
  logic [kcpl_pkg::IDX_W-1:0]      idx;
  logic                            idx_over;
  logic [kcpl_pkg::MAT_AW-1:0]     m_raddr;

  // finished result waiting for the output register
  logic signed [kcpl_pkg::WORD_W-1:0] hold_word;
  logic                            hold_oor;

  // ---------------------------------------------------------------- decode
  assign req_stall  = (state != ST_IDLE);
  assign req_take   = req_valid && !req_stall;
  assign take_query = req_take && (kind == kcpl_pkg::KIND_QUERY);
  assign slot_wide  = kcpl_pkg::WIDE_W'(slot);
  assign ld_entry   = {left_codepoint[kcpl_pkg::KEY_W-1:0], class_number};

  // loads beyond the depth of their store are dropped
  assign ld_left  = req_take && (kind == kcpl_pkg::KIND_LOAD_LEFT)
                    && (32'(slot) < kcpl_pkg::LEFT_ENTRIES);
  assign ld_right = req_take && (kind == kcpl_pkg::KIND_LOAD_RIGHT)
                    && (32'(slot) < kcpl_pkg::RIGHT_ENTRIES);
  assign ld_word  = req_take && (kind == kcpl_pkg::KIND_LOAD_WORD)
                    && (32'(slot) < kcpl_pkg::MATRIX_DEPTH);

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      kern_enable       <= 1'b0;
      left_entry_count  <= '0;
      right_entry_count <= '0;
      right_class_count <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        kcpl_pkg::REG_KERN_ENABLE:       kern_enable       <= cfg_data[0];
        kcpl_pkg::REG_LEFT_ENTRY_COUNT:  left_entry_count  <= cfg_data[kcpl_pkg::COUNT_W-1:0];
        kcpl_pkg::REG_RIGHT_ENTRY_COUNT: right_entry_count <= cfg_data[kcpl_pkg::COUNT_W-1:0];
        kcpl_pkg::REG_RIGHT_CLASS_COUNT: right_class_count <= cfg_data[kcpl_pkg::CLASS_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- search control
  // entry counts saturate at the table depth
  assign l_cnt_eff = (32'(left_entry_count) > kcpl_pkg::LEFT_ENTRIES)
                     ? kcpl_pkg::SRCH_W'(kcpl_pkg::LEFT_ENTRIES)
                     : kcpl_pkg::SRCH_W'(left_entry_count);
  assign r_cnt_eff = (32'(right_entry_count) > kcpl_pkg::RIGHT_ENTRIES)
                     ? kcpl_pkg::SRCH_W'(kcpl_pkg::RIGHT_ENTRIES)
                     : kcpl_pkg::SRCH_W'(right_entry_count);

  // empty table or codepoint beyond the 16-bit plane: no search at all
  assign l_skip = (l_cnt_eff == '0) || (left_codepoint[kcpl_pkg::CP_W-1:kcpl_pkg::KEY_W] != '0);
  assign r_skip = (r_cnt_eff == '0) || (right_codepoint[kcpl_pkg::CP_W-1:kcpl_pkg::KEY_W] != '0);

  assign l_step = kcpl_pkg::kcpl_probe(l_win, l_rdata[kcpl_pkg::ENTRY_W-1:kcpl_pkg::CLASS_W], l_cp);
  assign r_step = kcpl_pkg::kcpl_probe(r_win, r_rdata[kcpl_pkg::ENTRY_W-1:kcpl_pkg::CLASS_W], r_cp);

  // first probe is issued at the accepting edge, each later one from the step result
  assign l_raddr_w = (state == ST_IDLE) ? (l_cnt_eff >> 1) : kcpl_pkg::kcpl_addr(l_step);
  assign r_raddr_w = (state == ST_IDLE) ? (r_cnt_eff >> 1) : kcpl_pkg::kcpl_addr(r_step);
  // an address equal to the count only feeds a check that the count then rejects
  assign l_raddr   = l_raddr_w[kcpl_pkg::LEFT_AW-1:0];
  assign r_raddr   = r_raddr_w[kcpl_pkg::RIGHT_AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      l_ph <= PH_DONE;
      r_ph <= PH_DONE;
    end else if (take_query) begin
      l_ph   <= l_skip ? PH_DONE : PH_PROBE;
      r_ph   <= r_skip ? PH_DONE : PH_PROBE;
      l_win  <= '{lo: '0, n: l_cnt_eff};
      r_win  <= '{lo: '0, n: r_cnt_eff};
      l_cp   <= left_codepoint[kcpl_pkg::KEY_W-1:0];
      r_cp   <= right_codepoint[kcpl_pkg::KEY_W-1:0];
      l_cls  <= '0;
      r_cls  <= '0;
    end else if (state == ST_SEARCH) begin
      case (l_ph)
        PH_PROBE: begin
          l_win <= l_step;
          if (l_step.n == '0) begin
            l_ph <= PH_CHECK;
          end
        end
        PH_CHECK: begin
          if ((l_win.lo < l_cnt_eff)
              && (l_rdata[kcpl_pkg::ENTRY_W-1:kcpl_pkg::CLASS_W] == l_cp)) begin
            l_cls <= l_rdata[kcpl_pkg::CLASS_W-1:0];
          end
          l_ph <= PH_DONE;
        end
        default: ;
      endcase
      case (r_ph)
        PH_PROBE: begin
          r_win <= r_step;
          if (r_step.n == '0) begin
            r_ph <= PH_CHECK;
          end
        end
        PH_CHECK: begin
          if ((r_win.lo < r_cnt_eff)
              && (r_rdata[kcpl_pkg::ENTRY_W-1:kcpl_pkg::CLASS_W] == r_cp)) begin
            r_cls <= r_rdata[kcpl_pkg::CLASS_W-1:0];
          end
          r_ph <= PH_DONE;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- memories
  always_ff @(posedge clk) begin
    if (ld_left) begin
      left_mem[slot_wide[kcpl_pkg::LEFT_AW-1:0]] <= ld_entry;
    end
    l_rdata <= left_mem[l_raddr];
  end

  always_ff @(posedge clk) begin
    if (ld_right) begin
      right_mem[slot_wide[kcpl_pkg::RIGHT_AW-1:0]] <= ld_entry;
    end
    r_rdata <= right_mem[r_raddr];
  end

  always_ff @(posedge clk) begin
    if (ld_word) begin
      mat_mem[slot_wide[kcpl_pkg::MAT_AW-1:0]] <= kern_word;
    end
    m_rdata <= mat_mem[m_raddr];
  end

  // ---------------------------------------------------------------- matrix index
  // a zero class wraps here but is masked through pair_ok
  assign lc_m1    = l_cls - kcpl_pkg::CLASS_W'(1);
  assign idx      = prod + kcpl_pkg::IDX_W'(rc_m1);
  assign idx_over = (32'(idx) >= kcpl_pkg::MATRIX_DEPTH);
  assign m_raddr  = idx[kcpl_pkg::MAT_AW-1:0];

  // ---------------------------------------------------------------- sequencer and output
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      // in delivery the output register is reloaded by the state itself
      if (res_valid && !res_stall && (state != ST_DELIVER)) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (take_query) begin
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if ((l_ph == PH_DONE) && (r_ph == PH_DONE)) begin
            state <= ST_MULT;
          end
        end
        ST_MULT: begin
          prod    <= kcpl_pkg::IDX_W'(lc_m1) * kcpl_pkg::IDX_W'(right_class_count);
          rc_m1   <= r_cls - kcpl_pkg::CLASS_W'(1);
          pair_ok <= kern_enable && (l_cls != '0) && (r_cls != '0);
          state   <= ST_INDEX;
        end
        ST_INDEX: begin
          hold_word <= '0;
          hold_oor  <= 1'b0;
          if (!pair_ok) begin
            state <= ST_DELIVER;
          end else if (idx_over) begin
            hold_oor <= 1'b1;
            state    <= ST_DELIVER;
          end else begin
            state <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          hold_word <= m_rdata;
          state     <= ST_DELIVER;
        end
        ST_DELIVER: begin
          if (!res_valid || !res_stall) begin
            res_valid    <= 1'b1;
            kern_adjust  <= hold_word;
            out_of_range <= hold_oor;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- assertions
  // a load never keeps the block busy
  a_load_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && (kind != kcpl_pkg::KIND_QUERY)) |=> !req_stall)
    else $error("block busy after a load request");

  // a query always occupies the block on the following cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && (kind == kcpl_pkg::KIND_QUERY)) |=> req_stall)
    else $error("query request did not start a lookup");

  // both searches have finished before the index is formed
  a_search_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MULT) |-> ((l_ph == PH_DONE) && (r_ph == PH_DONE)))
    else $error("index formed before both searches finished");

  // an out of range index never carries a kern value
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && out_of_range) |-> (kern_adjust == '0))
    else $error("out of range result with nonzero adjustment");

endmodule

`default_nettype wire
